### rtl/core/ctsim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsim_pkg
// Shared widths, constants and types of the counted Tanimoto similarity unit.
// ----------------------------------------------------------------------------
package ctsim_pkg;

  localparam int COUNT_W       = 8;
  localparam int TOTAL_W       = 20;
  localparam int SUM_W         = 20;
  localparam int FRAC_W        = 16;
  localparam int SIM_W         = FRAC_W + 1;
  localparam int MAX_POSITIONS = 4096;

  localparam int ACC_LIMIT_INT = (MAX_POSITIONS * 255 > (2 ** SUM_W) - 1) ?
                                 (2 ** SUM_W) - 1 : MAX_POSITIONS * 255;
  localparam logic [SUM_W-1:0] ACC_LIMIT = ACC_LIMIT_INT[SUM_W-1:0];

  localparam logic [SIM_W-1:0] Q_ONE  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [SIM_W-1:0] Q_ZERO = '0;

  // denominator na + nb - bic, signed, two bits of growth plus sign
  localparam int DEN_W   = TOTAL_W + 3;
  // remainder stays below the denominator, which is below 2^(TOTAL_W+1)
  localparam int REM_W   = TOTAL_W + 1;
  localparam int STEP_W  = $clog2(FRAC_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [SUM_W-1:0]   bic;
    logic [TOTAL_W-1:0] na;
    logic [TOTAL_W-1:0] nb;
  } ctsim_job_t;

endpackage

### rtl/core/ctsim_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsim_front
// Accepts count pairs, sums the smaller count with saturation and hands a
// job to the queue on the last position of a run.
// ----------------------------------------------------------------------------
module ctsim_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ctsim_pkg::COUNT_W-1:0]   count_left,
  input  logic [ctsim_pkg::COUNT_W-1:0]   count_right,
  input  logic [ctsim_pkg::TOTAL_W-1:0]   total_left,
  input  logic [ctsim_pkg::TOTAL_W-1:0]   total_right,
  input  logic                            last_position,
  output logic                            job_valid,
  input  logic                            job_ready,
  output ctsim_pkg::ctsim_job_t           job
);

  logic [ctsim_pkg::SUM_W-1:0]   acc;
  logic [ctsim_pkg::SUM_W-1:0]   acc_next;
  logic [ctsim_pkg::COUNT_W-1:0] min_count;
  logic [ctsim_pkg::SUM_W:0]     sum_wide;
  logic [ctsim_pkg::SUM_W-1:0]   sum_sat;
  logic                          take;

  assign in_ready  = job_ready;
  assign take      = in_valid && in_ready;
  assign min_count = (count_left < count_right) ? count_left : count_right;
  assign sum_wide  = {1'b0, acc} + {{(ctsim_pkg::SUM_W + 1 - ctsim_pkg::COUNT_W){1'b0}},
                     min_count};
  assign sum_sat   = (sum_wide > {1'b0, ctsim_pkg::ACC_LIMIT}) ? ctsim_pkg::ACC_LIMIT :
                     sum_wide[ctsim_pkg::SUM_W-1:0];

  assign job_valid = take && last_position;
  assign job.bic   = sum_sat;
  assign job.na    = total_left;
  assign job.nb    = total_right;

  always_comb begin
    acc_next = acc;
    if (take) begin
      acc_next = last_position ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

endmodule

### rtl/core/ctsim_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsim_queue
// Small register queue of finished runs between the front and the divider.
// ----------------------------------------------------------------------------
module ctsim_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  not_full,
  input  ctsim_pkg::ctsim_job_t push_job,
  output logic                  not_empty,
  input  logic                  pop,
  output ctsim_pkg::ctsim_job_t head
);

  ctsim_pkg::ctsim_job_t              slots [ctsim_pkg::QUEUE_DEPTH];
  logic [ctsim_pkg::QPTR_W-1:0]       wr_ptr;
  logic [ctsim_pkg::QPTR_W-1:0]       rd_ptr;
  logic [ctsim_pkg::QCNT_W-1:0]       fill;
  logic                               do_push;
  logic                               do_pop;

  assign not_full  = (fill != ctsim_pkg::QCNT_W'(ctsim_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ctsim_pkg::QPTR_W'(ctsim_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ctsim_pkg::QPTR_W'(ctsim_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/core/ctsim_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsim_back
// Resolves the special cases and runs a one-bit-per-cycle restoring divider
// for the Q1.16 ratio; holds the result in an output register.
// ----------------------------------------------------------------------------
module ctsim_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_pop,
  input  ctsim_pkg::ctsim_job_t         job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctsim_pkg::SUM_W-1:0]   common_sum,
  output logic [ctsim_pkg::SIM_W-1:0]   similarity
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [ctsim_pkg::REM_W-1:0]     rem;
  logic [ctsim_pkg::REM_W-1:0]     den;
  logic [ctsim_pkg::FRAC_W-1:0]    quot;
  logic [ctsim_pkg::STEP_W-1:0]    step;
  logic [ctsim_pkg::SUM_W-1:0]     bic;
  logic [ctsim_pkg::SIM_W-1:0]     sim_res;

  logic signed [ctsim_pkg::DEN_W-1:0] den_s;
  logic signed [ctsim_pkg::DEN_W-1:0] bic_s;
  logic                               is_special;
  logic [ctsim_pkg::SIM_W-1:0]        special_val;
  logic [ctsim_pkg::REM_W:0]          shifted;
  logic                               fits;
  logic                               out_free;

  assign bic_s = $signed({{(ctsim_pkg::DEN_W - ctsim_pkg::SUM_W){1'b0}}, job.bic});
  assign den_s = $signed({{(ctsim_pkg::DEN_W - ctsim_pkg::TOTAL_W){1'b0}}, job.na})
               + $signed({{(ctsim_pkg::DEN_W - ctsim_pkg::TOTAL_W){1'b0}}, job.nb})
               - bic_s;

  always_comb begin
    is_special  = 1'b0;
    special_val = ctsim_pkg::Q_ONE;
    if (job.bic == '0) begin
      is_special  = 1'b1;
      special_val = (job.na == '0 && job.nb == '0) ? ctsim_pkg::Q_ONE : ctsim_pkg::Q_ZERO;
    end else if (den_s <= bic_s) begin
      is_special  = 1'b1;
      special_val = ctsim_pkg::Q_ONE;
    end
  end

  assign shifted  = {rem, 1'b0};
  assign fits     = (shifted >= {1'b0, den});
  assign out_free = !out_valid || out_ready;
  assign job_pop  = (state == ST_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            bic     <= job.bic;
            sim_res <= is_special ? special_val : ctsim_pkg::Q_ZERO;
            rem     <= {{(ctsim_pkg::REM_W - ctsim_pkg::SUM_W){1'b0}}, job.bic};
            den     <= den_s[ctsim_pkg::REM_W-1:0];
            quot    <= '0;
            step    <= '0;
            state   <= is_special ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= fits ? (shifted[ctsim_pkg::REM_W-1:0] - den) :
                  shifted[ctsim_pkg::REM_W-1:0];
          quot <= {quot[ctsim_pkg::FRAC_W-2:0], fits};
          step <= step + 1'b1;
          if (step == ctsim_pkg::STEP_W'(ctsim_pkg::FRAC_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (sim_res == '0 && bic != '0) begin
            sim_res <= {1'b0, quot};
          end
          if (out_free) begin
            common_sum <= bic;
            similarity <= (sim_res == '0 && bic != '0) ? {1'b0, quot} : sim_res;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/counted_tanimoto_similarity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counted_tanimoto_similarity_unit
// Sums the smaller count of each fingerprint position pair and gives the
// summed minimum and the Tanimoto ratio in Q1.16 at the end of each run.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_*      in   tdata: count_left[7:0] count_right[15:8] total_left[35:16]
//                       total_right[55:36]; tlast: last_position
//  m_*      out  tdata: common_sum[19:0] similarity[36:20], zero fill to 40
//
//  Count pairs are taken one per cycle. Each run end queues a job; the divider
//  resolves the special cases directly and runs a bit-serial division otherwise,
//  then loads the output register; it takes a new job only after that load.
//  Input stalls only when the 2-entry job queue is full. Synchronous reset
//  clears the accumulator, queue and output valid.
// ----------------------------------------------------------------------------
module counted_tanimoto_similarity_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // count_left, count_right, total_left, total_right
  input  logic [ctsim_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // common_sum, similarity, zero fill
  output logic [ctsim_pkg::OUT_DATA_W-1:0]     m_tdata
);

  ctsim_pkg::ctsim_job_t           front_job;
  ctsim_pkg::ctsim_job_t           head_job;
  logic                            front_valid;
  logic                            queue_not_full;
  logic                            queue_not_empty;
  logic                            back_pop;
  logic [ctsim_pkg::SUM_W-1:0]     common_sum;
  logic [ctsim_pkg::SIM_W-1:0]     similarity;

  ctsim_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .count_left    (s_tdata[7:0]),
    .count_right   (s_tdata[15:8]),
    .total_left    (s_tdata[35:16]),
    .total_right   (s_tdata[55:36]),
    .last_position (s_tlast),
    .job_valid     (front_valid),
    .job_ready     (queue_not_full),
    .job           (front_job)
  );

  ctsim_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .not_full  (queue_not_full),
    .push_job  (front_job),
    .not_empty (queue_not_empty),
    .pop       (back_pop),
    .head      (head_job)
  );

  ctsim_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (queue_not_empty),
    .job_pop    (back_pop),
    .job        (head_job),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .common_sum (common_sum),
    .similarity (similarity)
  );

  assign m_tdata = {{(ctsim_pkg::OUT_DATA_W - ctsim_pkg::SUM_W - ctsim_pkg::SIM_W){1'b0}},
                    similarity, common_sum};

endmodule
